FILE: hw/rtl/tlru_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// TLB and demand paging package
// Shared constants, controller command and status types.
// ----------------------------------------------------------------------------
package tlru_pkg;

    localparam int OFFSET_WIDTH_DEF = 12;
    localparam int PAGE_WIDTH_DEF   = 10;
    localparam int FRAME_COUNT_DEF  = 256;
    localparam int TLB_DEPTH_DEF    = 32;

    localparam int ADDR_W  = 22;
    localparam int PAGE_W  = 10;
    localparam int FRAME_W = 8;
    localparam int PHYS_W  = 20;
    localparam int OCC_W   = 6;

    typedef struct packed {
        logic latch;
        logic pm_read;
        logic resolve;
        logic owner_read;
        logic evict;
        logic fill;
        logic emit;
    } tlru_cmd_t;

    typedef struct packed {
        logic hit;
        logic present;
        logic need_evict;
        logic clearing;
    } tlru_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tlru_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module tlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/tlru_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Controller
// Sequences lookup, page table access, eviction and TLB fill.
// ----------------------------------------------------------------------------
module tlru_ctrl
    import tlru_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire tlru_sts_t sts,
    output tlru_cmd_t      cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOOK  = 7'b0000010,
        S_PMRD  = 7'b0000100,
        S_OWN   = 7'b0001000,
        S_EVICT = 7'b0010000,
        S_FILL  = 7'b0100000,
        S_CLEAR = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (!sts.clearing)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (sts.hit)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.pm_read = 1'b1;
                    state_next = S_PMRD;
                end
            end
            S_PMRD:
            begin
                cmd.resolve = 1'b1;
                if (!sts.present && sts.need_evict)
                begin
                    cmd.owner_read = 1'b1;
                    state_next = S_OWN;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_OWN:
            begin
                cmd.evict = 1'b1;
                state_next = S_EVICT;
            end
            S_EVICT:
            begin
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                cmd.emit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |=> !busy)
        else $error("Result not followed by idle.");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.latch |=> busy)
        else $error("Accepted request did not make the block busy.");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.evict |-> busy)
        else $error("Evict issued while idle.");
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0({cmd.fill, cmd.pm_read,
        cmd.evict})) else $error("Conflicting datapath commands.");
endmodule
`default_nettype wire

FILE: hw/rtl/tlru_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Datapath
// TLB slots with LRU ranks, page map and frame owner memories, result register.
// ----------------------------------------------------------------------------
module tlru_dp
    import tlru_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    parameter int PAGE_WIDTH   = PAGE_WIDTH_DEF,
    parameter int FRAME_COUNT  = FRAME_COUNT_DEF,
    parameter int TLB_DEPTH    = TLB_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tlru_cmd_t         cmd,
    output tlru_sts_t              sts,
    input  wire logic [ADDR_W-1:0] logical_address,
    output logic                   done,
    output logic [PAGE_W-1:0]      page_number,
    output logic                   tlb_hit,
    output logic                   page_fault,
    output logic [FRAME_W-1:0]     frame_number,
    output logic [PHYS_W-1:0]      physical_address,
    output logic                   memory_evicted,
    output logic [PAGE_W-1:0]      evicted_page,
    output logic                   tlb_flushed,
    output logic                   tlb_replaced,
    output logic [PAGE_W-1:0]      replaced_page,
    output logic [OCC_W-1:0]       tlb_occupancy
);
    localparam int PAGES = 1 << PAGE_WIDTH;
    localparam int PW = PAGE_WIDTH;
    localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int SW = $clog2(TLB_DEPTH);
    localparam int CW = $clog2(TLB_DEPTH + 1);
    localparam int UW = $clog2(FRAME_COUNT + 1);
    localparam int PMW = FW + 1;

    logic [TLB_DEPTH-1:0] valid_reg;
    logic [PW-1:0] tpage_reg [TLB_DEPTH];
    logic [FW-1:0] tframe_reg [TLB_DEPTH];
    logic [SW-1:0] rank_reg [TLB_DEPTH];
    logic [CW-1:0] count_reg;
    logic [UW-1:0] used_reg;
    logic [FW-1:0] vptr_reg;
    logic          clr_reg;
    logic [PW-1:0] clr_addr_reg;

    logic [PW-1:0]           page_reg;
    logic [OFFSET_WIDTH-1:0] off_reg;
    logic [FW-1:0]           frame_reg;
    logic                    hit_reg, fault_reg, evic_reg, flush_reg;
    logic [PW-1:0]           epage_reg;
    logic [SW-1:0]           hslot_reg;

    logic [PMW-1:0] pm_rdata, pm_wdata;
    logic [PW-1:0]  pm_waddr, pm_raddr;
    logic           pm_we;
    logic [PW-1:0]  own_rdata;
    logic           own_we;

    tlru_ram #(.WIDTH(PMW), .DEPTH(PAGES)) u_pm (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr), .rdata(pm_rdata));
    tlru_ram #(.WIDTH(PW), .DEPTH(FRAME_COUNT)) u_own (
        .clk(clk), .we(own_we), .waddr(frame_reg), .wdata(page_reg),
        .raddr(vptr_reg), .rdata(own_rdata));

    logic [TLB_DEPTH-1:0] match;
    logic                 any_match;
    logic [SW-1:0]        match_slot;
    logic [SW-1:0]        free_slot, lru_slot, fill_slot;
    logic                 full;

    always_comb
    begin
        match = '0;
        any_match = 1'b0;
        match_slot = '0;
        free_slot = '0;
        lru_slot = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (tpage_reg[i] == (cmd.evict ? own_rdata : page_reg));
            if (match[i])
            begin
                match_slot = SW'(i);
            end
            if (!valid_reg[i])
            begin
                free_slot = SW'(i);
            end
            if (rank_reg[i] == SW'(TLB_DEPTH - 1))
            begin
                lru_slot = SW'(i);
            end
        end
        any_match = |match;
        full = (count_reg == CW'(TLB_DEPTH));
        fill_slot = full ? lru_slot : free_slot;
    end

    assign pm_raddr = page_reg;
    always_comb
    begin
        pm_we = 1'b0;
        pm_waddr = page_reg;
        pm_wdata = {1'b1, frame_reg};
        own_we = 1'b0;
        if (clr_reg)
        begin
            pm_we = 1'b1;
            pm_waddr = clr_addr_reg;
            pm_wdata = '0;
        end
        else if (cmd.evict)
        begin
            pm_we = 1'b1;
            pm_waddr = own_rdata;
            pm_wdata = '0;
        end
        else if (cmd.fill && fault_reg)
        begin
            pm_we = 1'b1;
            own_we = 1'b1;
        end
    end

    assign sts.hit = any_match;
    assign sts.present = pm_rdata[PMW-1];
    assign sts.need_evict = (used_reg == UW'(FRAME_COUNT));
    assign sts.clearing = clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < TLB_DEPTH; i++)
            begin
                rank_reg[i] <= '0;
            end
            count_reg <= '0;
            used_reg <= '0;
            vptr_reg <= '0;
            clr_reg <= 1'b1;
            clr_addr_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.emit;
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == PW'(PAGES - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (cmd.latch)
            begin
                hit_reg <= 1'b0;
                fault_reg <= 1'b0;
                evic_reg <= 1'b0;
                flush_reg <= 1'b0;
                epage_reg <= '0;
            end
            if (cmd.emit && !cmd.fill)
            begin
                hit_reg <= 1'b1;
                frame_reg <= tframe_reg[match_slot];
                for (int i = 0; i < TLB_DEPTH; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] < rank_reg[match_slot])
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
                rank_reg[match_slot] <= '0;
            end
            if (cmd.resolve)
            begin
                if (pm_rdata[PMW-1])
                begin
                    frame_reg <= pm_rdata[FW-1:0];
                end
                else
                begin
                    fault_reg <= 1'b1;
                    if (used_reg == UW'(FRAME_COUNT))
                    begin
                        frame_reg <= vptr_reg;
                        evic_reg <= 1'b1;
                        vptr_reg <= (vptr_reg == FW'(FRAME_COUNT - 1)) ? '0 : vptr_reg + 1'b1;
                    end
                    else
                    begin
                        frame_reg <= used_reg[FW-1:0];
                        used_reg <= used_reg + 1'b1;
                    end
                end
            end
            if (cmd.evict)
            begin
                epage_reg <= own_rdata;
                if (any_match)
                begin
                    flush_reg <= 1'b1;
                    valid_reg[match_slot] <= 1'b0;
                    rank_reg[match_slot] <= '0;
                    count_reg <= count_reg - 1'b1;
                    for (int i = 0; i < TLB_DEPTH; i++)
                    begin
                        if (valid_reg[i] && rank_reg[i] > rank_reg[match_slot])
                        begin
                            rank_reg[i] <= rank_reg[i] - 1'b1;
                        end
                    end
                end
            end
            if (cmd.fill)
            begin
                valid_reg[fill_slot] <= 1'b1;
                rank_reg[fill_slot] <= '0;
                if (!full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                for (int i = 0; i < TLB_DEPTH; i++)
                begin
                    if (valid_reg[i] && SW'(i) != fill_slot)
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            page_reg <= logical_address[OFFSET_WIDTH +: PW];
            off_reg <= logical_address[OFFSET_WIDTH-1:0];
            tlb_replaced <= 1'b0;
            replaced_page <= '0;
        end
        if (cmd.fill)
        begin
            tpage_reg[fill_slot] <= page_reg;
            tframe_reg[fill_slot] <= frame_reg;
            tlb_replaced <= full;
            replaced_page <= full ? PAGE_W'(tpage_reg[fill_slot]) : '0;
        end
    end

    assign page_number = PAGE_W'(page_reg);
    assign tlb_hit = hit_reg;
    assign page_fault = fault_reg;
    assign frame_number = FRAME_W'(frame_reg);
    assign physical_address = PHYS_W'({frame_reg, off_reg});
    assign memory_evicted = evic_reg;
    assign evicted_page = PAGE_W'(epage_reg);
    assign tlb_flushed = flush_reg;
    assign tlb_occupancy = OCC_W'(count_reg);

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(TLB_DEPTH))
        else $error("TLB count overflow.");
    assert property (@(posedge clk) disable iff (!rst_n) $countones(valid_reg) == count_reg)
        else $error("TLB count disagrees with valid bits.");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.evict |-> !clr_reg)
        else $error("Eviction during clearing pass.");
endmodule
`default_nettype wire

FILE: hw/rtl/tlb_lru_demand_paging_mmu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// TLB with LRU replacement and FIFO demand paging
// Translates one logical address per request and reports the result.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// The page number is the field above the low OFFSET_WIDTH offset bits.
// Each request produces one result, valid for one cycle while done is high;
// the receiver cannot stall, so it must take the result in that cycle.
// On a TLB hit the result follows the lookup. On a miss with the page present or
// a fault with a free frame, the page table is read and then the TLB is filled;
// on a fault that evicts a frame, the page table read is followed by the frame
// owner read and the eviction before the fill.
// busy stays high while a request is in flight, so a new request can be
// accepted in the cycle that done is shown.
// After reset the TLB is empty and a clearing pass writes every page table
// entry to not present, one per cycle, with busy high.
// ----------------------------------------------------------------------------
module tlb_lru_demand_paging_mmu_core
    import tlru_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    parameter int PAGE_WIDTH   = PAGE_WIDTH_DEF,
    parameter int FRAME_COUNT  = FRAME_COUNT_DEF,
    parameter int TLB_DEPTH    = TLB_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ADDR_W-1:0] logical_address,
    output logic                   done,
    output logic [PAGE_W-1:0]      page_number,
    output logic                   tlb_hit,
    output logic                   page_fault,
    output logic [FRAME_W-1:0]     frame_number,
    output logic [PHYS_W-1:0]      physical_address,
    output logic                   memory_evicted,
    output logic [PAGE_W-1:0]      evicted_page,
    output logic                   tlb_flushed,
    output logic                   tlb_replaced,
    output logic [PAGE_W-1:0]      replaced_page,
    output logic [OCC_W-1:0]       tlb_occupancy
);
    tlru_cmd_t cmd;
    tlru_sts_t sts;

    tlru_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd));

    tlru_dp #(
        .OFFSET_WIDTH(OFFSET_WIDTH), .PAGE_WIDTH(PAGE_WIDTH),
        .FRAME_COUNT(FRAME_COUNT), .TLB_DEPTH(TLB_DEPTH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .logical_address(logical_address), .done(done),
        .page_number(page_number), .tlb_hit(tlb_hit), .page_fault(page_fault),
        .frame_number(frame_number), .physical_address(physical_address),
        .memory_evicted(memory_evicted), .evicted_page(evicted_page),
        .tlb_flushed(tlb_flushed), .tlb_replaced(tlb_replaced),
        .replaced_page(replaced_page), .tlb_occupancy(tlb_occupancy));
endmodule
`default_nettype wire

FILE: tb/tlb_lru_demand_paging_mmu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translation result checker
// Watches the request and result channels of the translation core, keeps
// its own model of the TLB, page map and frame pool, predicts each result
// and compares it field by field with what the core reports.
// ----------------------------------------------------------------------------
module tlb_lru_demand_paging_mmu_checker
    import tlru_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [ADDR_W-1:0] logical_address,
    input  wire logic              done,
    input  wire logic [PAGE_W-1:0] page_number,
    input  wire logic              tlb_hit,
    input  wire logic              page_fault,
    input  wire logic [FRAME_W-1:0] frame_number,
    input  wire logic [PHYS_W-1:0] physical_address,
    input  wire logic              memory_evicted,
    input  wire logic [PAGE_W-1:0] evicted_page,
    input  wire logic              tlb_flushed,
    input  wire logic              tlb_replaced,
    input  wire logic [PAGE_W-1:0] replaced_page,
    input  wire logic [OCC_W-1:0]  tlb_occupancy,
    output int                     fail_count,
    output int                     pending_count
);

    localparam int OFS_W = OFFSET_WIDTH_DEF;
    localparam int NFRAMES = FRAME_COUNT_DEF;
    localparam int NSLOTS = TLB_DEPTH_DEF;
    localparam int NPAGES = 1 << PAGE_WIDTH_DEF;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic               hit;
        logic               fault;
        logic [FRAME_W-1:0] frame;
        logic [PHYS_W-1:0]  phys;
        logic               evicted;
        logic [PAGE_W-1:0]  epage;
        logic               flushed;
        logic               replaced;
        logic [PAGE_W-1:0]  rpage;
        logic [OCC_W-1:0]   occ;
    } xlate_t;

    logic               slot_valid [NSLOTS];
    logic [PAGE_W-1:0]  slot_page [NSLOTS];
    logic [FRAME_W-1:0] slot_frame [NSLOTS];
    int                 slot_rank [NSLOTS];
    logic               pg_present [NPAGES];
    logic [FRAME_W-1:0] pg_frame [NPAGES];
    logic [PAGE_W-1:0]  owner [NFRAMES];
    int                 used_frames;
    int                 fifo_ptr;
    int                 occupancy;
    xlate_t             expected_q [$];

    function automatic int find_slot(logic [PAGE_W-1:0] pg);
        for (int i = 0; i < NSLOTS; i++)
            if (slot_valid[i] && slot_page[i] == pg)
                return i;
        return -1;
    endfunction

    function automatic xlate_t translate(logic [ADDR_W-1:0] addr);
        xlate_t r;
        int s;
        int old;
        logic [PAGE_W-1:0] pg;
        int fr;
        r = '0;
        pg = addr[OFS_W +: PAGE_W];
        r.page = pg;
        s = find_slot(pg);
        if (s >= 0)
        begin
            r.hit = 1'b1;
            fr = int'(slot_frame[s]);
            old = slot_rank[s];
            for (int i = 0; i < NSLOTS; i++)
                if (i != s && slot_valid[i] && slot_rank[i] < old)
                    slot_rank[i]++;
            slot_rank[s] = 0;
        end
        else
        begin
            if (pg_present[pg])
            begin
                fr = int'(pg_frame[pg]);
            end
            else
            begin
                r.fault = 1'b1;
                if (used_frames < NFRAMES)
                begin
                    fr = used_frames;
                    used_frames++;
                end
                else
                begin
                    fr = fifo_ptr;
                    fifo_ptr = (fifo_ptr + 1) % NFRAMES;
                    r.evicted = 1'b1;
                    r.epage = owner[fr];
                    pg_present[r.epage] = 1'b0;
                    s = find_slot(r.epage);
                    if (s >= 0)
                    begin
                        old = slot_rank[s];
                        r.flushed = 1'b1;
                        slot_valid[s] = 1'b0;
                        slot_rank[s] = 0;
                        for (int i = 0; i < NSLOTS; i++)
                            if (slot_valid[i] && slot_rank[i] > old)
                                slot_rank[i]--;
                        occupancy--;
                    end
                end
                owner[fr] = pg;
                pg_present[pg] = 1'b1;
                pg_frame[pg] = FRAME_W'(fr);
            end
            s = -1;
            if (occupancy < NSLOTS)
            begin
                for (int i = 0; i < NSLOTS; i++)
                    if (!slot_valid[i] && s < 0)
                        s = i;
            end
            if (s >= 0)
            begin
                for (int i = 0; i < NSLOTS; i++)
                    if (slot_valid[i])
                        slot_rank[i]++;
                occupancy++;
            end
            else
            begin
                s = 0;
                for (int i = 1; i < NSLOTS; i++)
                    if (slot_rank[i] > slot_rank[s])
                        s = i;
                r.replaced = 1'b1;
                r.rpage = slot_page[s];
                for (int i = 0; i < NSLOTS; i++)
                    if (i != s && slot_valid[i])
                        slot_rank[i]++;
            end
            slot_valid[s] = 1'b1;
            slot_page[s] = pg;
            slot_frame[s] = FRAME_W'(fr);
            slot_rank[s] = 0;
        end
        r.frame = FRAME_W'(fr);
        r.phys = {r.frame, addr[OFS_W-1:0]};
        r.occ = OCC_W'(occupancy);
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < NSLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_rank[i] = 0;
        end
        for (int i = 0; i < NPAGES; i++)
            pg_present[i] = 1'b0;
        used_frames = 0;
        fifo_ptr = 0;
        occupancy = 0;
        fail_count = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        xlate_t got;
        xlate_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{page_number, tlb_hit, page_fault, frame_number, physical_address,
                        memory_evicted, evicted_page, tlb_flushed, tlb_replaced,
                        replaced_page, tlb_occupancy};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(translate(logical_address));
            pending_count = expected_q.size();
        end
    end

endmodule

FILE: tb/tlb_lru_demand_paging_mmu_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translation core testbench
// Sends directed and random address requests with random idle gaps and
// lets the checker judge every result; gives the final verdict.
// ----------------------------------------------------------------------------
module tlb_lru_demand_paging_mmu_core_tb;
    import tlru_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [ADDR_W-1:0] logical_address = '0;
    logic              busy;
    logic              done;
    logic [PAGE_W-1:0] page_number;
    logic              tlb_hit;
    logic              page_fault;
    logic [FRAME_W-1:0] frame_number;
    logic [PHYS_W-1:0] physical_address;
    logic              memory_evicted;
    logic [PAGE_W-1:0] evicted_page;
    logic              tlb_flushed;
    logic              tlb_replaced;
    logic [PAGE_W-1:0] replaced_page;
    logic [OCC_W-1:0]  tlb_occupancy;
    int                fail_count;
    int                pending_count;
    int                idle_pct;
    logic [PAGE_W-1:0] hot_pages [48];

    always #2 clk = ~clk;

    tlb_lru_demand_paging_mmu_core DUT (.*);

    tlb_lru_demand_paging_mmu_checker u_checker (.*);

    task automatic issue(logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        logical_address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] addr_of(logic [PAGE_W-1:0] pg);
        return {pg, 12'($urandom)};
    endfunction

    initial
    begin
        idle_pct = 35;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        issue('0);
        issue('1);
        issue('0);
        issue({10'd0, 12'hFFF});
        for (int i = 1; i <= 34; i++)
            issue(addr_of(PAGE_W'(i)));
        issue(addr_of(PAGE_W'(1)));
        issue(addr_of(PAGE_W'(35)));

        for (int i = 0; i < 48; i++)
            hot_pages[i] = PAGE_W'($urandom);
        for (int n = 0; n < 700; n++)
        begin
            if (n == 230)
                idle_pct = 62;
            if (n == 460)
                idle_pct = 0;
            if (n == 350)
            begin
                start <= 1'b0;
                while (pending_count != 0)
                    @(negedge clk);
            end
            if ($urandom_range(99) < 60)
                issue(addr_of(hot_pages[$urandom_range(47)]));
            else
                issue(ADDR_W'($urandom));
        end
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
